/* src/hkr_pkg.sv */
// Shared types and constants for the heap key replace block.
// Used by hkr_core and heap_key_replace; depends on nothing else.
package hkr_pkg;

	localparam int HEAP_DEPTH_DEF = 1024;

	localparam int POS_W   = 11;
	localparam int COST_W  = 32;
	localparam int ANGLE_W = 32;
	localparam int ROW_W   = 16;
	localparam int COL_W   = 16;
	localparam int STAT_W  = 2;

	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 16;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_REPLACE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [ANGLE_W-1:0] angle;
		logic [COST_W-1:0]  cost;
	} entry_t;

	typedef struct packed {
		logic             action;
		logic [POS_W-1:0] position;
		entry_t           entry;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  final_position;
	} rsp_t;

endpackage

/* src/hkr_core.sv */
// Heap storage and update sequencer: one entry memory, search, sift up, sift down.
// Depends on hkr_pkg.
module hkr_core #(
	parameter int HEAP_DEPTH = hkr_pkg::HEAP_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  hkr_pkg::cmd_t cmd,
	output logic          done,
	output hkr_pkg::rsp_t rsp
);

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = (CW > hkr_pkg::POS_W) ? CW : hkr_pkg::POS_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_UP_RD  = 3'd2;
	localparam logic [2:0] S_UP_CMP = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_RL  = 3'd5;
	localparam logic [2:0] S_DN_RR  = 3'd6;
	localparam logic [2:0] S_WRITE  = 3'd7;

	hkr_pkg::entry_t mem [HEAP_DEPTH];

	logic [2:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   iss_q;
	logic [CW-1:0]   child_q;
	logic [CW-1:0]   idx_s1;
	logic            rvalid_s1;
	hkr_pkg::entry_t key_q;
	hkr_pkg::entry_t left_q;
	hkr_pkg::entry_t rdata_s1;
	logic            done_q;
	hkr_pkg::rsp_t   rsp_q;

	logic            rd_en, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	hkr_pkg::entry_t wr_data;

	logic [XW-1:0]   pos_x;
	logic            pos_ok;
	logic [CW:0]     child_w;
	logic [CW:0]     cnt_x;
	logic            match;
	logic            take_right;
	hkr_pkg::entry_t sel;
	logic [CW-1:0]   sel_idx;

	function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] idx);
		logic [CW-1:0] a;
		a = idx - CW'(1);
		return a[AW-1:0];
	endfunction

	assign pos_x      = XW'(cmd.position);
	assign pos_ok     = (pos_x != '0) && (pos_x <= XW'(HEAP_DEPTH));
	assign child_w    = {idx_q, 1'b0};
	assign cnt_x      = {1'b0, count_q};
	assign match      = (rdata_s1.row == key_q.row) && (rdata_s1.col == key_q.col);
	assign take_right = left_q.cost > rdata_s1.cost;
	assign sel        = take_right ? rdata_s1 : left_q;
	assign sel_idx    = take_right ? (child_q + CW'(1)) : child_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = slot_addr(idx_q);
		wr_data = key_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && cmd.action == hkr_pkg::ACT_LOAD && pos_ok) begin
					wr_en   = 1'b1;
					wr_addr = slot_addr(CW'(pos_x));
					wr_data = cmd.entry;
				end
			end
			S_SEARCH: begin
				rd_en   = iss_q != '0;
				rd_addr = slot_addr(iss_q);
			end
			S_UP_RD: begin
				rd_en   = idx_q > CW'(1);
				rd_addr = slot_addr(idx_q >> 1);
			end
			S_UP_CMP: begin
				wr_en   = key_q.cost < rdata_s1.cost;
				wr_data = rdata_s1;
			end
			S_DN_RD: begin
				rd_en   = child_w <= cnt_x;
				rd_addr = slot_addr(child_w[CW-1:0]);
			end
			S_DN_RL: begin
				if (child_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = slot_addr(child_q + CW'(1));
				end else begin
					wr_en   = key_q.cost > rdata_s1.cost;
					wr_data = rdata_s1;
				end
			end
			S_DN_RR: begin
				wr_en   = key_q.cost > sel.cost;
				wr_data = sel;
			end
			S_WRITE: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= cmd.entry;
						if (cmd.action == hkr_pkg::ACT_LOAD) begin
							done_q               <= 1'b1;
							rsp_q.status         <= hkr_pkg::ST_OK;
							rsp_q.final_position <= pos_ok ? cmd.position : '0;
							if (pos_ok) begin
								count_q <= CW'(pos_x);
							end
						end else if (count_q == '0) begin
							done_q               <= 1'b1;
							rsp_q.status         <= hkr_pkg::ST_EMPTY;
							rsp_q.final_position <= '0;
						end else begin
							iss_q     <= count_q;
							rvalid_s1 <= 1'b0;
							state_q   <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					rvalid_s1 <= iss_q != '0;
					idx_s1    <= iss_q;
					if (iss_q != '0) begin
						iss_q <= iss_q - CW'(1);
					end
					if (rvalid_s1 && match) begin
						idx_q   <= idx_s1;
						state_q <= S_UP_RD;
					end else if (rvalid_s1 && idx_s1 == CW'(1)) begin
						done_q               <= 1'b1;
						rsp_q.status         <= hkr_pkg::ST_NOT_FOUND;
						rsp_q.final_position <= '0;
						state_q              <= S_IDLE;
					end
				end
				S_UP_RD: begin
					state_q <= (idx_q > CW'(1)) ? S_UP_CMP : S_DN_RD;
				end
				S_UP_CMP: begin
					if (key_q.cost < rdata_s1.cost) begin
						idx_q   <= idx_q >> 1;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_DN_RD;
					end
				end
				S_DN_RD: begin
					if (child_w <= cnt_x) begin
						child_q <= child_w[CW-1:0];
						state_q <= S_DN_RL;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_DN_RL: begin
					left_q <= rdata_s1;
					if (child_q < count_q) begin
						state_q <= S_DN_RR;
					end else if (key_q.cost > rdata_s1.cost) begin
						idx_q   <= child_q;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_DN_RR: begin
					if (key_q.cost > sel.cost) begin
						idx_q   <= sel_idx;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					done_q               <= 1'b1;
					rsp_q.status         <= hkr_pkg::ST_OK;
					rsp_q.final_position <= hkr_pkg::POS_W'(idx_q);
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* src/heap_key_replace.sv */
// Top level of the heap key replace block: stream ports, transaction tracking, output register.
// Depends on hkr_pkg and hkr_core.

// A 1-based binary min-heap of cells (cost, angle, row, column) lives in one
// single-port-read, single-port-write memory of HEAP_DEPTH words. A load
// transaction (tuser = 0) writes one slot and sets the entry count to that slot;
// a position of zero or above HEAP_DEPTH writes nothing and answers ok with
// position 0. A replace transaction (tuser = 1) scans from the last entry down
// to entry 1 for the matching row and column, installs the new cost and angle,
// sifts the entry up and then down, and answers ok with its final slot, or
// "empty" / "not found" with position 0 and the heap untouched. One item is in
// work at a time. A load, or a replace on an empty heap, is answered from the
// idle state through the done register and the output register. A replace
// reads the parent and compares for each level moved up, reads the left and
// then the right child (where one exists) for each level moved down, and
// finishes with the last compares, the write-back and the output register. A
// miss is answered once the scan has read slot 1. The scan loop issues one
// memory read each cycle. The memory needs no clearing after reset.
module heap_key_replace #(
	parameter int HEAP_DEPTH = hkr_pkg::HEAP_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// position[10:0], new_cost[42:11], new_angle[74:43], cell_row[90:75],
	// cell_col[106:91], zero fill[111:107]
	input  logic [hkr_pkg::S_TDATA_W-1:0] s_tdata,
	// action[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], final_position[12:2], zero fill[15:13]
	output logic [hkr_pkg::M_TDATA_W-1:0] m_tdata
);

	hkr_pkg::cmd_t cmd;
	hkr_pkg::rsp_t core_rsp;
	logic          core_done;
	logic          accept;
	logic          busy_q;
	logic          m_tvalid_q;
	logic [hkr_pkg::M_TDATA_W-1:0] m_tdata_q;

	// Unpack the input transaction, lowest field first.
	assign cmd.action      = s_tuser;
	assign cmd.position    = s_tdata[10:0];
	assign cmd.entry.cost  = s_tdata[42:11];
	assign cmd.entry.angle = s_tdata[74:43];
	assign cmd.entry.row   = s_tdata[90:75];
	assign cmd.entry.col   = s_tdata[106:91];

	// Take a new item only when none is in work and the output slot is free by
	// the next edge, so a finished result never has to wait for room.
	assign s_tready = !busy_q && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	hkr_core #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.cmd   (cmd),
		.done  (core_done),
		.rsp   (core_rsp)
	);

	// Track the item in work: set on accept, drop when the core reports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (core_done) begin
			busy_q <= 1'b0;
		end
	end

	// Output register: load on completion, hold until the downstream takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (core_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			m_tdata_q <= {3'b000, core_rsp.final_position, core_rsp.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A completion always belongs to an accepted item.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> busy_q)
		else $error("completion without an item in work");

	// The output slot is free whenever a result arrives.
	a_done_room: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> !m_tvalid_q)
		else $error("result would overwrite a pending result");

	// Error answers carry position zero.
	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(core_done && core_rsp.status != hkr_pkg::ST_OK) |-> (core_rsp.final_position == '0))
		else $error("error result with nonzero position");

endmodule
